// ----- rtl/deq_pkg.sv -----
// Shared types, constants and ring index helpers for the double-ended queue.
package deq_pkg;

  // Ring capacity and the widths that follow from it.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Action codes; the unused codes behave as a peek.
  typedef enum logic [2:0] {
    ACT_PEEK       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Command transaction payload.
  typedef struct packed {
    logic [2:0]               action;
    logic signed [WORD_W-1:0] push_value;
  } deq_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } deq_out_t;

  // Ring position of offset b from index a; for b at or below the capacity,
  // one compare and subtract wraps the sum.
  function automatic idx_t ring_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(CAPACITY)) begin
      s = s - (CNT_W + 1)'(CAPACITY);
    end
    return IDX_W'(s);
  endfunction

endpackage

// ----- rtl/double_ended_queue_top.sv -----
// Double-ended queue of signed words in a ring held in one synchronous RAM.
// A command is taken when start_i is high and busy_o is low; the block then steps
// through S_FRONT, S_BACK and S_EMIT, and done_o rises with the registered result
// as it returns to idle. A new command is not taken until the last one is through,
// since the front and back words are read one after the other through the single
// RAM read port. busy_o stays high until idle; the receiver cannot stall results.
// Reset empties the queue (head and count to zero); the RAM is not cleared.
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  deq_in_t  cmd_i,
  output logic     busy_o,
  output logic     done_o,
  output deq_out_t result_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FRONT = 4'b0010,
    S_BACK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  idx_t             head_q, head_d;
  cnt_t             cnt_q, cnt_d;
  status_e          status_q, status_d;
  logic [WORD_W-1:0] front_q;
  logic             done_q;
  deq_out_t         result_q;

  logic              ram_we;
  idx_t              ram_waddr;
  idx_t              ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              is_full;
  logic              is_empty;
  idx_t              head_prev;
  idx_t              back_idx;

  assign is_full   = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty  = (cnt_q == '0);
  assign head_prev = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;
  assign back_idx  = ring_add(head_q, cnt_q - 1'b1);

  // Word storage.
  deq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.push_value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Command decode, pointer update and sequencing of the two reads.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = head_prev;
    ram_raddr = (state_q == S_FRONT) ? head_q : back_idx;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d  = S_FRONT;
          status_d = STAT_OK;
          unique case (action_e'(cmd_i.action))
            ACT_PUSH_FRONT: begin
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = head_prev;
                head_d    = head_prev;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            ACT_PUSH_BACK: begin
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head_q, cnt_q);
                cnt_d     = cnt_q + 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                head_d = ring_add(head_q, CNT_W'(1));
                cnt_d  = cnt_q - 1'b1;
              end
            end
            ACT_POP_BACK: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            ACT_CLEAR: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                head_d = '0;
                cnt_d  = '0;
              end
            end
            default: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end
            end
          endcase
        end
      end
      S_FRONT: state_d = S_BACK;
      S_BACK:  state_d = S_EMIT;
      S_EMIT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      status_q <= STAT_OK;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      done_q   <= (state_q == S_EMIT);
    end
  end

  // Read data capture and result register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_BACK) begin
      front_q <= ram_rdata;
    end
    if (state_q == S_EMIT) begin
      result_q.status      <= status_q;
      result_q.front_value <= is_empty ? '0 : front_q;
      result_q.back_value  <= is_empty ? '0 : ram_rdata;
      result_q.count       <= COUNT_W'(cnt_q);
      result_q.is_empty    <= is_empty;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/double_ended_queue_checker.sv -----
// Port-level assertions for the double-ended queue and their bind.
module double_ended_queue_checker
  import deq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     done_o,
  input deq_out_t result_o
);

  // An accepted command shows its result strobe after its front, back and emit states.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result strobe missing after accepted transaction");

  // The block is busy while a transaction is in flight.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // A result is only shown once the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An empty queue reports zero words and a zero count.
  a_empty_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.is_empty) |->
      (result_o.front_value == '0 && result_o.back_value == '0 &&
       result_o.count == '0))
    else $error("empty result carries nonzero fields");

  // Status codes stay in their defined range.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == STAT_OK || result_o.status == STAT_EMPTY ||
                result_o.status == STAT_FULL))
    else $error("undefined status code");

endmodule

bind double_ended_queue_top double_ended_queue_checker u_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .result_o(result_o)
);
